// ----- rtl/afd_pkg.sv -----
// Shared types and constants for the accelerometer fall detector.
// Payload structs, configuration register file, phase codes and reset values.
// No dependencies; every other file in rtl/ imports this package.
package afd_pkg;

  // Widths of the data path
  localparam int AccelW = 16;
  localparam int TimeW  = 32;
  localparam int MagW   = 32;
  localparam int ThrW   = 32;
  localparam int MsW    = 16;
  localparam int SqW    = 31;  // largest square is 32768^2 = 2^30
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FREEFALL_MAG_SQ     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IMPACT_MAG_SQ       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REST_LOW_MAG_SQ     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REST_HIGH_MAG_SQ    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FREEFALL_MIN_MS     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FREEFALL_TIMEOUT_MS = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_MS           = 3'd6;

  // Reset values: 0.4 g, 3 g, 0.8 g, 1.2 g squared at 16384 counts per g
  localparam logic [ThrW-1:0] RST_FREEFALL_MAG_SQ  = 32'd42949673;
  localparam logic [ThrW-1:0] RST_IMPACT_MAG_SQ    = 32'd2415919104;
  localparam logic [ThrW-1:0] RST_REST_LOW_MAG_SQ  = 32'd171798692;
  localparam logic [ThrW-1:0] RST_REST_HIGH_MAG_SQ = 32'd386547057;
  localparam logic [MsW-1:0]  RST_FREEFALL_MIN_MS  = 16'd30;
  localparam logic [MsW-1:0]  RST_FREEFALL_TIMEOUT_MS = 16'd2000;
  localparam logic [MsW-1:0]  RST_SETTLE_MS        = 16'd10000;

  // Detection phase
  typedef enum logic [1:0] {
    PH_NORMAL   = 2'd0,
    PH_FREEFALL = 2'd1,
    PH_IMPACT   = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
    logic signed [AccelW-1:0] accel_z;
    logic [TimeW-1:0]         now_ms;
  } in_t;

  typedef struct packed {
    logic       fall_confirmed;
    logic [1:0] phase;
  } out_t;

  // Live configuration handed to the merge stage
  typedef struct packed {
    logic [ThrW-1:0] freefall_mag_sq;
    logic [ThrW-1:0] impact_mag_sq;
    logic [ThrW-1:0] rest_low_mag_sq;
    logic [ThrW-1:0] rest_high_mag_sq;
    logic [MsW-1:0]  freefall_min_ms;
    logic [MsW-1:0]  freefall_timeout_ms;
    logic [MsW-1:0]  settle_ms;
  } cfg_t;

endpackage

// ----- rtl/afd_sq_lane.sv -----
// One squaring lane: registers the square of one signed axis sample.
// Depends on afd_pkg for widths.
module afd_sq_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [afd_pkg::AccelW-1:0]  sample,
  output logic [afd_pkg::SqW-1:0]            sq
);
  import afd_pkg::*;

  logic signed [2*AccelW-1:0] prod;

  // Square is never negative and never above 2^30
  assign prod = sample * sample;

  // Capture on pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      sq <= prod[SqW-1:0];
    end
  end

endmodule

// ----- rtl/afd_merge.sv -----
// Merge stage: sums the lane squares, compares against thresholds and runs
// the three-phase detector. Holds the phase state and the result register.
// Depends on afd_pkg for types and phase codes.
module afd_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic [afd_pkg::SqW-1:0]   sq_x,
  input  logic [afd_pkg::SqW-1:0]   sq_y,
  input  logic [afd_pkg::SqW-1:0]   sq_z,
  input  logic [afd_pkg::TimeW-1:0] now_ms,
  input  afd_pkg::cfg_t             cfg,
  output afd_pkg::out_t             result
);
  import afd_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [TimeW-1:0]  freefall_start;
  logic [TimeW-1:0]  freefall_start_next;
  logic [TimeW-1:0]  impact_time;
  logic [TimeW-1:0]  impact_time_next;
  logic              confirmed_next;

  logic [MagW-1:0]   mag;
  logic [TimeW-1:0]  start_eff;
  logic [TimeW-1:0]  ff_elapsed;
  logic [TimeW-1:0]  arm_elapsed;
  logic [TimeW-1:0]  settle_elapsed;
  logic              low_g;
  logic              high_g;
  logic              in_rest;
  logic              timed_out;
  logic              settled;
  logic              min_passed;

  // Combine lanes; the sum of three squares fits in 32 bits
  assign mag = {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};

  assign low_g   = mag < cfg.freefall_mag_sq;
  assign high_g  = mag > cfg.impact_mag_sq;
  assign in_rest = (mag < cfg.rest_high_mag_sq) && (mag > cfg.rest_low_mag_sq);

  // Elapsed times wrap modulo 2^32; a zero start means not armed yet
  assign start_eff      = (freefall_start == '0) ? now_ms : freefall_start;
  assign arm_elapsed    = now_ms - start_eff;
  assign ff_elapsed     = now_ms - freefall_start;
  assign settle_elapsed = now_ms - impact_time;
  assign min_passed = arm_elapsed    > {{(TimeW-MsW){1'b0}}, cfg.freefall_min_ms};
  assign timed_out  = ff_elapsed     > {{(TimeW-MsW){1'b0}}, cfg.freefall_timeout_ms};
  assign settled    = settle_elapsed > {{(TimeW-MsW){1'b0}}, cfg.settle_ms};

  // Next phase and timestamps
  always_comb begin
    phase_next          = phase;
    freefall_start_next = freefall_start;
    impact_time_next    = impact_time;
    unique case (phase)
      PH_FREEFALL: begin
        if (high_g) begin
          impact_time_next = now_ms;
          phase_next       = PH_IMPACT;
        end
        // Timeout wins over an impact in the same sample
        if (timed_out) begin
          phase_next          = PH_NORMAL;
          freefall_start_next = '0;
        end
      end
      PH_IMPACT: begin
        if (settled) begin
          phase_next = PH_NORMAL;
        end
      end
      default: begin
        if (low_g) begin
          freefall_start_next = start_eff;
          if (min_passed) begin
            phase_next = PH_FREEFALL;
          end
        end else begin
          freefall_start_next = '0;
        end
      end
    endcase
  end

  // Fall confirmation
  always_comb begin
    confirmed_next = (phase == PH_IMPACT) && settled && in_rest;
  end

  // Update state on each transfer into this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_NORMAL;
      freefall_start <= '0;
      impact_time    <= '0;
    end else if (adv) begin
      phase          <= phase_next;
      freefall_start <= freefall_start_next;
      impact_time    <= impact_time_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      result.fall_confirmed <= confirmed_next;
      result.phase          <= phase_next;
    end
  end

  a_confirm_ends_normal: assert property (@(posedge clk) disable iff (rst)
    confirmed_next |-> phase_next == PH_NORMAL)
    else $error("fall confirmed without returning to normal");

  a_freefall_armed: assert property (@(posedge clk) disable iff (rst)
    adv && phase == PH_NORMAL && phase_next == PH_FREEFALL |-> freefall_start_next != '0)
    else $error("free fall entered without an armed start time");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(phase) && $stable(impact_time) && $stable(freefall_start))
    else $error("detector state changed without a transfer");

  a_impact_time_taken: assert property (@(posedge clk) disable iff (rst)
    adv && phase == PH_FREEFALL && phase_next == PH_IMPACT |=> impact_time == $past(now_ms))
    else $error("impact phase entered without latching the impact time");

endmodule

// ----- rtl/accel_fall_detector.sv -----
// Top level of the accelerometer fall detector.
// Instantiates three afd_sq_lane squaring lanes and the afd_merge stage;
// holds the configuration registers and the pipeline handshake. Uses afd_pkg.
//
// Accepts one sample per clock unless the result side stalls, and returns one result
// per sample. Each axis is squared in its own lane; the merge stage adds the squares,
// compares them with the squared thresholds and updates the phase, so the phase
// loop closes in that stage and sets the rate at one item per clock. A stalled
// result waits in the output register while the lanes take one more sample;
// after that in_ready drops until the result is taken. Configuration writes are
// taken in any cycle (cfg_ready is always high); indexes beyond settle_ms
// are ignored. Write configuration only while no sample is in flight.
module accel_fall_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  afd_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output afd_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [afd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [afd_pkg::CfgDataW-1:0]    cfg_data
);
  import afd_pkg::*;

  cfg_t              cfg;
  logic              s1_valid;
  logic [TimeW-1:0]  s1_now;
  logic [SqW-1:0]    sq_x;
  logic [SqW-1:0]    sq_y;
  logic [SqW-1:0]    sq_z;
  logic              take_in;
  logic              adv;

  // Pipeline flow: lanes, then merge with the output register
  assign adv       = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || adv;
  assign take_in   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Carry the timestamp alongside the lanes
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_now <= in_data.now_ms;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freefall_mag_sq     <= RST_FREEFALL_MAG_SQ;
      cfg.impact_mag_sq       <= RST_IMPACT_MAG_SQ;
      cfg.rest_low_mag_sq     <= RST_REST_LOW_MAG_SQ;
      cfg.rest_high_mag_sq    <= RST_REST_HIGH_MAG_SQ;
      cfg.freefall_min_ms     <= RST_FREEFALL_MIN_MS;
      cfg.freefall_timeout_ms <= RST_FREEFALL_TIMEOUT_MS;
      cfg.settle_ms           <= RST_SETTLE_MS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FREEFALL_MAG_SQ:     cfg.freefall_mag_sq     <= cfg_data[ThrW-1:0];
        REG_IMPACT_MAG_SQ:       cfg.impact_mag_sq       <= cfg_data[ThrW-1:0];
        REG_REST_LOW_MAG_SQ:     cfg.rest_low_mag_sq     <= cfg_data[ThrW-1:0];
        REG_REST_HIGH_MAG_SQ:    cfg.rest_high_mag_sq    <= cfg_data[ThrW-1:0];
        REG_FREEFALL_MIN_MS:     cfg.freefall_min_ms     <= cfg_data[MsW-1:0];
        REG_FREEFALL_TIMEOUT_MS: cfg.freefall_timeout_ms <= cfg_data[MsW-1:0];
        REG_SETTLE_MS:           cfg.settle_ms           <= cfg_data[MsW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Squaring lanes, one per axis
  afd_sq_lane u_lane_x (
    .clk    (clk),
    .en     (take_in),
    .sample (in_data.accel_x),
    .sq     (sq_x)
  );

  afd_sq_lane u_lane_y (
    .clk    (clk),
    .en     (take_in),
    .sample (in_data.accel_y),
    .sq     (sq_y)
  );

  afd_sq_lane u_lane_z (
    .clk    (clk),
    .en     (take_in),
    .sample (in_data.accel_z),
    .sq     (sq_z)
  );

  // Sum, compare and phase update
  afd_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .sq_x   (sq_x),
    .sq_y   (sq_y),
    .sq_z   (sq_z),
    .now_ms (s1_now),
    .cfg    (cfg),
    .result (out_data)
  );

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid)
    else $error("lane stage lost a sample");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled while the pipeline had room");

  a_result_follows_merge: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("merge transfer did not produce a result");

endmodule

// ----- tb/accel_fall_detector_tb.sv -----
// Self-checking testbench for accel_fall_detector: sample, result and config channels.
// Tracks the three detection phases in its own shadow model; depends on afd_pkg and
// rtl/accel_fall_detector.sv, which pulls in afd_sq_lane and afd_merge.
`timescale 1ns / 1ps

module accel_fall_detector_tb;
  import afd_pkg::*;

  localparam int           PIPE_LATENCY = 2;
  localparam int           WATCHDOG_LIMIT = 2000;
  localparam int           LONG_HOLD = 400;
  localparam int           MAX_REPORTS = 10;
  localparam logic [31:0]  MAG_SQ_MAX = 32'd3221225472;
  localparam logic [15:0]  MS_MAX = 16'hFFFF;
  // Index past the last register; the block must ignore writes to it
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

  typedef enum {
    K_LOW,
    K_HIT,
    K_REST,
    K_NOISE
  } motion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Shadow copy of the detector state and its live settings
  phase_t fall_phase = PH_NORMAL;
  logic [31:0] armed_at_ms = '0;
  logic [31:0] impact_at_ms = '0;
  cfg_t live_cfg = '{
    freefall_mag_sq: RST_FREEFALL_MAG_SQ,
    impact_mag_sq: RST_IMPACT_MAG_SQ,
    rest_low_mag_sq: RST_REST_LOW_MAG_SQ,
    rest_high_mag_sq: RST_REST_HIGH_MAG_SQ,
    freefall_min_ms: RST_FREEFALL_MIN_MS,
    freefall_timeout_ms: RST_FREEFALL_TIMEOUT_MS,
    settle_ms: RST_SETTLE_MS
  };

  out_t fall_reports[$];
  logic [31:0] sample_ms = '0;
  int failures = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_results = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  accel_fall_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Advance the shadow detector by one sample and return the report it makes
  function automatic out_t step_detector(in_t s);
    longint ax, ay, az;
    logic [31:0] mag, now, elapsed;
    out_t r;
    ax = longint'($signed(s.accel_x));
    ay = longint'($signed(s.accel_y));
    az = longint'($signed(s.accel_z));
    mag = 32'(ax * ax + ay * ay + az * az);
    now = s.now_ms;
    r = '0;
    case (fall_phase)
      PH_FREEFALL: begin
        if (mag > live_cfg.impact_mag_sq) begin
          impact_at_ms = now;
          fall_phase = PH_IMPACT;
        end
        // timeout overrides an impact seen in the same sample
        elapsed = now - armed_at_ms;
        if (elapsed > 32'(live_cfg.freefall_timeout_ms)) begin
          fall_phase = PH_NORMAL;
          armed_at_ms = '0;
        end
      end
      PH_IMPACT: begin
        elapsed = now - impact_at_ms;
        if (elapsed > 32'(live_cfg.settle_ms)) begin
          r.fall_confirmed = (mag < live_cfg.rest_high_mag_sq) &&
                             (mag > live_cfg.rest_low_mag_sq);
          fall_phase = PH_NORMAL;
        end
      end
      default: begin
        if (mag < live_cfg.freefall_mag_sq) begin
          // zero marks "not armed", so a zero timestamp cannot arm
          if (armed_at_ms == '0) armed_at_ms = now;
          elapsed = now - armed_at_ms;
          if (elapsed > 32'(live_cfg.freefall_min_ms)) fall_phase = PH_FREEFALL;
        end else begin
          armed_at_ms = '0;
        end
      end
    endcase
    r.phase = fall_phase;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 75) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [15:0] axis_value(int lo, int hi);
    int v;
    v = $urandom_range(hi, lo);
    if ($urandom_range(1, 0)) v = -v;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic in_t make_sample(logic signed [15:0] x, logic signed [15:0] y,
                                      logic signed [15:0] z, logic [31:0] t);
    in_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    s.now_ms = t;
    return s;
  endfunction

  function automatic in_t shaped_sample(motion_t k, logic [31:0] t);
    in_t s;
    case (k)
      K_LOW: s = make_sample(axis_value(0, 1500), axis_value(0, 1500), axis_value(0, 1500), t);
      K_HIT: s = make_sample(axis_value(29000, 32768), axis_value(29000, 32768),
                             axis_value(29000, 32768), t);
      K_REST: begin
        s = make_sample(axis_value(0, 2000), axis_value(0, 2000), axis_value(0, 2000), t);
        // put gravity on a random axis
        case ($urandom_range(2, 0))
          0: s.accel_x = axis_value(14884, 17884);
          1: s.accel_y = axis_value(14884, 17884);
          default: s.accel_z = axis_value(14884, 17884);
        endcase
      end
      default: s = make_sample(16'($urandom), 16'($urandom), 16'($urandom), t);
    endcase
    return s;
  endfunction

  // Pick the next sample from the current phase so most runs walk a full fall
  function automatic in_t next_sample();
    int roll;
    motion_t k;
    logic [31:0] tmo, settle;
    roll = $urandom_range(99, 0);
    tmo = 32'(live_cfg.freefall_timeout_ms);
    settle = 32'(live_cfg.settle_ms);
    case (fall_phase)
      PH_FREEFALL: begin
        if (roll < 55) begin
          sample_ms += $urandom_range(20, 1);
          k = K_HIT;
        end else if (roll < 70) begin
          sample_ms += $urandom_range(tmo + 300, tmo + 1);
          k = (roll < 63) ? K_HIT : K_LOW;
        end else begin
          sample_ms += $urandom_range(40, 0);
          k = K_LOW;
        end
      end
      PH_IMPACT: begin
        if (roll < 40) begin
          sample_ms += $urandom_range(200, 0);
          k = K_NOISE;
        end else begin
          sample_ms += $urandom_range(settle + 200, settle + 1);
          k = (roll < 85) ? K_REST : K_NOISE;
        end
      end
      default: begin
        if (roll < 65) begin
          sample_ms += $urandom_range(20, 0);
          k = K_LOW;
        end else begin
          sample_ms += $urandom_range(60, 0);
          k = (roll < 85) ? K_REST : K_NOISE;
        end
      end
    endcase
    if ($urandom_range(99, 0) < 8) k = K_NOISE;
    if ($urandom_range(199, 0) == 0) sample_ms = $urandom;
    return shaped_sample(k, sample_ms);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.freefall_mag_sq = $urandom_range(32'd150000000, 32'd10000000);
    c.impact_mag_sq = $urandom_range(32'd2600000000, 32'd1500000000);
    c.rest_low_mag_sq = $urandom_range(32'd200000000, 32'd100000000);
    c.rest_high_mag_sq = $urandom_range(32'd600000000, 32'd250000000);
    c.freefall_min_ms = 16'($urandom_range(200, 0));
    c.freefall_timeout_ms = 16'($urandom_range(3000, 50));
    c.settle_ms = 16'($urandom_range(12000, 0));
    return c;
  endfunction

  // Offer one sample; valid stays high afterwards until the next gap or drain
  task automatic offer_sample(in_t s);
    int gap;
    gap = no_idle ? 0 : (($urandom_range(99, 0) < 60) ? 0 : idle_length());
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    fall_reports.push_back(step_detector(s));
  endtask

  // Stop offering and wait until every report is back
  task automatic drain();
    in_valid <= 1'b0;
    while (fall_reports.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Write every register, plus the unused index; junk fills the upper bits of
  // the 16-bit registers when asked
  task automatic program_settings(cfg_t c, bit junk_upper);
    logic [CfgIdxW-1:0] sel;
    logic [CfgDataW-1:0] val;
    logic [15:0] upper;
    for (int i = 0; i <= int'(REG_SPARE); i++) begin
      sel = i[CfgIdxW-1:0];
      upper = junk_upper ? 16'($urandom) : 16'h0000;
      case (sel)
        REG_FREEFALL_MAG_SQ: val = c.freefall_mag_sq;
        REG_IMPACT_MAG_SQ: val = c.impact_mag_sq;
        REG_REST_LOW_MAG_SQ: val = c.rest_low_mag_sq;
        REG_REST_HIGH_MAG_SQ: val = c.rest_high_mag_sq;
        REG_FREEFALL_MIN_MS: val = {upper, c.freefall_min_ms};
        REG_FREEFALL_TIMEOUT_MS: val = {upper, c.freefall_timeout_ms};
        REG_SETTLE_MS: val = {upper, c.settle_ms};
        default: val = $urandom;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= sel;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
      case (sel)
        REG_FREEFALL_MAG_SQ: live_cfg.freefall_mag_sq = val;
        REG_IMPACT_MAG_SQ: live_cfg.impact_mag_sq = val;
        REG_REST_LOW_MAG_SQ: live_cfg.rest_low_mag_sq = val;
        REG_REST_HIGH_MAG_SQ: live_cfg.rest_high_mag_sq = val;
        REG_FREEFALL_MIN_MS: live_cfg.freefall_min_ms = val[15:0];
        REG_FREEFALL_TIMEOUT_MS: live_cfg.freefall_timeout_ms = val[15:0];
        REG_SETTLE_MS: live_cfg.settle_ms = val[15:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) offer_sample(next_sample());
    drain();
  endtask

  // Walk the phases by hand with the reset settings
  task automatic test_directed_falls();
    // arming at time zero is skipped; the next low sample arms
    offer_sample(make_sample(0, 0, 16384, 0));
    offer_sample(make_sample(0, 0, 0, 0));
    offer_sample(make_sample(100, -100, 0, 20));
    offer_sample(make_sample(0, 0, 0, 51));
    // largest magnitude is an impact
    offer_sample(make_sample(-32768, -32768, -32768, 60));
    offer_sample(make_sample(0, 0, 16384, 10060));
    offer_sample(make_sample(0, 0, 16384, 10061));
    // stale arm: the start from before the impact is still held
    offer_sample(make_sample(0, 0, 0, 10070));
    // impact and timeout in one sample: timeout wins
    offer_sample(make_sample(32767, 32767, 32767, 10080));
    offer_sample(make_sample(0, 0, 0, 10100));
    offer_sample(make_sample(0, 0, 0, 10131));
    offer_sample(make_sample(0, 0, 16384, 12132));
    // impact while normal only clears the arm
    offer_sample(make_sample(-32768, 32767, -32768, 12140));
    offer_sample(make_sample(32767, -32768, 0, 19990));
    // minimum time is exclusive
    offer_sample(make_sample(0, 0, 0, 20000));
    offer_sample(make_sample(0, 0, 0, 20030));
    offer_sample(make_sample(0, 0, 0, 20031));
    offer_sample(make_sample(32767, 32767, 32767, 20040));
    offer_sample(make_sample(32767, 0, 0, 30041));
    // timestamps wrap through zero
    offer_sample(make_sample(0, 0, 16384, 32'hFFFF_FFE0));
    offer_sample(make_sample(0, 0, 0, 32'hFFFF_FFF0));
    offer_sample(make_sample(0, 0, 0, 32'h0000_000F));
    offer_sample(make_sample(-32768, -32768, 32767, 32'h0000_0020));
    offer_sample(make_sample(0, 0, 0, 32'h0000_2731));
    drain();
  endtask

  task automatic test_threshold_extremes();
    cfg_t c;
    // nothing is low, every band is open, no waiting
    c = '{freefall_mag_sq: '0, impact_mag_sq: MAG_SQ_MAX, rest_low_mag_sq: '0,
          rest_high_mag_sq: MAG_SQ_MAX, freefall_min_ms: '0, freefall_timeout_ms: '0,
          settle_ms: '0};
    program_settings(c, 1'b0);
    run_random(120);
    // almost everything low and an impact, longest waits
    c = '{freefall_mag_sq: MAG_SQ_MAX, impact_mag_sq: '0, rest_low_mag_sq: '0,
          rest_high_mag_sq: MAG_SQ_MAX, freefall_min_ms: MS_MAX,
          freefall_timeout_ms: MS_MAX, settle_ms: MS_MAX};
    program_settings(c, 1'b1);
    run_random(120);
    // same with no waiting, so phases turn over fast
    c.freefall_min_ms = '0;
    c.freefall_timeout_ms = '0;
    c.settle_ms = '0;
    program_settings(c, 1'b0);
    run_random(120);
  endtask

  task automatic test_random_settings();
    repeat (6) begin
      program_settings(random_settings(), $urandom_range(3, 0) == 0);
      no_idle = ($urandom_range(3, 0) == 0);
      run_random(200);
      no_idle = 1'b0;
    end
  endtask

  task automatic test_reset_settings();
    cfg_t c;
    c = '{freefall_mag_sq: RST_FREEFALL_MAG_SQ, impact_mag_sq: RST_IMPACT_MAG_SQ,
          rest_low_mag_sq: RST_REST_LOW_MAG_SQ, rest_high_mag_sq: RST_REST_HIGH_MAG_SQ,
          freefall_min_ms: RST_FREEFALL_MIN_MS,
          freefall_timeout_ms: RST_FREEFALL_TIMEOUT_MS, settle_ms: RST_SETTLE_MS};
    program_settings(c, 1'b0);
    run_random(150);
  endtask

  // Hold the result side off for a long stretch while samples keep coming
  task automatic test_output_backpressure();
    no_idle = 1'b1;
    hold_results = 1'b1;
    run_random(80);
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, or one long hold when requested
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(99, 0) < 25) stall_left = idle_length();
      end
    end
  end

  // Compare each result transfer with the oldest expected report
  always @(posedge clk) begin : report_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (fall_reports.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: confirmed=%0d phase=%0d",
                   out_data.fall_confirmed, out_data.phase);
      end else begin
        want = fall_reports.pop_front();
        if (out_data.fall_confirmed !== want.fall_confirmed || out_data.phase !== want.phase)
        begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("mismatch: expected confirmed=%0d phase=%0d, got confirmed=%0d phase=%0d",
                     want.fall_confirmed, want.phase, out_data.fall_confirmed, out_data.phase);
        end
      end
    end
  end

  // End the run when no channel has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_falls();
    sample_ms = $urandom;
    test_threshold_extremes();
    test_random_settings();
    test_reset_settings();
    test_output_backpressure();
    drain();
    if (failures == 0 && fall_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
